### hdl/assert_macros.svh
// Assertion macros used by the top level of the palette band sequencer.
// Standalone header, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/bps_pkg.sv
// Shared types and constants of the palette band sequencer.
// No dependencies.
package bps_pkg;

  localparam int MaxBandsDefault = 8;
  localparam int MaxResults      = 8;

  localparam logic [7:0] WaitLine    = 8'd143;
  localparam logic [7:0] BandLines   = 8'd8;
  localparam logic [2:0] HalfB       = 3'd3;
  localparam logic [2:0] RestoreSlot = 3'd6;
  localparam logic       KindPal     = 1'b0;
  localparam logic       KindLine    = 1'b1;

  typedef enum logic [2:0] {
    CFG_ENABLE         = 3'd0,
    CFG_FIRST_LINE     = 3'd1,
    CFG_END_LINE       = 3'd2,
    CFG_BAND_COUNT     = 3'd3,
    CFG_RESTORE_ENABLE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       enable;
    logic [7:0] first_line;
    logic [7:0] end_line;
    logic [3:0] band_count;
    logic       restore_enable;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] slot;
    logic       from_restore;
    logic [4:0] palette_index;
    logic [7:0] line_value;
    logic       wait_window;
  } entry_t;

  typedef struct packed {
    entry_t [MaxResults-1:0] entries;
    logic [3:0]              count;
  } plan_t;

endpackage

### hdl/bps_cfg.sv
// Configuration register file of the palette band sequencer.
// Depends on bps_pkg.
module bps_cfg
  import bps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:         cfg_d.enable         = cfg_data_i[0];
        CFG_FIRST_LINE:     cfg_d.first_line     = cfg_data_i;
        CFG_END_LINE:       cfg_d.end_line       = cfg_data_i;
        CFG_BAND_COUNT:     cfg_d.band_count     = cfg_data_i[3:0];
        CFG_RESTORE_ENABLE: cfg_d.restore_enable = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hdl/bps_plan.sv
// Input register, phase counter and per-event result planning.
// Depends on bps_pkg.
module bps_plan
  import bps_pkg::*;
#(
  parameter int MAX_BANDS = MaxBandsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] current_line_i,
  output logic       plan_valid_o,
  input  logic       plan_ready_i,
  output plan_t      plan_o
);

  localparam logic [3:0] MaxBandsW = 4'(MAX_BANDS);

  logic       a_valid_q;
  logic       a_action_q;
  logic [7:0] a_line_q;
  logic [3:0] phase_q, phase_d;
  logic       a_move;

  logic [3:0] bands;
  logic [3:0] ph_inc;
  logic [5:0] ph3;
  logic       wait_w;
  logic       t0_en, t1_en, w6_en, ln_en;
  logic [2:0] t0_slot, t1_slot;
  logic       t0_fr, t1_fr;
  logic [4:0] t0_idx, t1_idx;
  logic [7:0] ln_val;
  plan_t      plan;

  assign bands  = (cfg_i.band_count > MaxBandsW) ? MaxBandsW : cfg_i.band_count;
  assign ph_inc = (phase_q == 4'hF) ? phase_q : phase_q + 4'd1;
  assign ph3    = {1'b0, phase_q, 1'b0} + {2'b00, phase_q};
  assign wait_w = a_line_q < WaitLine;

  always_comb begin
    t0_en   = 1'b0;
    t1_en   = 1'b0;
    w6_en   = 1'b0;
    ln_en   = 1'b0;
    t0_slot = '0;
    t1_slot = '0;
    t0_fr   = 1'b0;
    t1_fr   = 1'b0;
    t0_idx  = '0;
    t1_idx  = '0;
    ln_val  = '0;
    phase_d = phase_q;
    if (cfg_i.enable) begin
      if (!a_action_q && cfg_i.restore_enable) begin
        t0_en   = 1'b1;
        t0_fr   = 1'b1;
        t1_en   = 1'b1;
        t1_slot = HalfB;
        t1_fr   = 1'b1;
        t1_idx  = {2'b00, HalfB};
        w6_en   = 1'b1;
        ln_en   = 1'b1;
        ln_val  = cfg_i.first_line - BandLines;
        phase_d = 4'd0;
      end else if (!a_action_q || phase_q == 4'd0) begin
        // lead-in: first one or two bands
        t0_en   = 1'b1;
        t1_en   = bands > 4'd1;
        t1_slot = HalfB;
        t1_idx  = {2'b00, HalfB};
        phase_d = 4'd2;
        if (bands > 4'd2) begin
          ln_en  = 1'b1;
          ln_val = cfg_i.first_line + BandLines;
        end else if (cfg_i.restore_enable) begin
          ln_en   = 1'b1;
          ln_val  = cfg_i.end_line - BandLines;
          phase_d = bands;
        end
      end else if (phase_q < bands) begin
        t0_en   = 1'b1;
        t0_slot = phase_q[0] ? HalfB : 3'd0;
        t0_idx  = ph3[4:0];
        phase_d = ph_inc;
        if ({1'b0, phase_q} + 5'd1 < {1'b0, bands}) begin
          ln_en  = 1'b1;
          ln_val = cfg_i.first_line + {1'b0, phase_q, 3'b000};
        end else if (cfg_i.restore_enable) begin
          ln_en  = 1'b1;
          ln_val = cfg_i.end_line - BandLines;
        end
      end else if (cfg_i.restore_enable && phase_q == bands) begin
        t0_en   = 1'b1;
        t0_slot = bands[0] ? HalfB : 3'd0;
        t0_fr   = 1'b1;
        t0_idx  = {2'b00, t0_slot};
        w6_en   = 1'b1;
        ln_en   = 1'b1;
        ln_val  = cfg_i.end_line;
        phase_d = ph_inc;
      end else if (cfg_i.restore_enable && {1'b0, phase_q} == {1'b0, bands} + 5'd1) begin
        t0_en   = 1'b1;
        t0_slot = bands[0] ? 3'd0 : HalfB;
        t0_fr   = 1'b1;
        t0_idx  = {2'b00, t0_slot};
        phase_d = ph_inc;
      end
    end
  end

  // expand the plan into the ordered result list
  always_comb begin
    logic [3:0] n;
    n    = '0;
    plan = '0;
    if (t0_en) begin
      for (int k = 0; k < 3; k++) begin
        plan.entries[n[2:0]] = '{kind: KindPal, slot: t0_slot + 3'(k), from_restore: t0_fr,
                                 palette_index: t0_idx + 5'(k), line_value: 8'd0,
                                 wait_window: wait_w};
        n = n + 4'd1;
      end
    end
    if (t1_en) begin
      for (int k = 0; k < 3; k++) begin
        plan.entries[n[2:0]] = '{kind: KindPal, slot: t1_slot + 3'(k), from_restore: t1_fr,
                                 palette_index: t1_idx + 5'(k), line_value: 8'd0,
                                 wait_window: wait_w};
        n = n + 4'd1;
      end
    end
    if (w6_en) begin
      plan.entries[n[2:0]] = '{kind: KindPal, slot: RestoreSlot, from_restore: 1'b1,
                               palette_index: {2'b00, RestoreSlot}, line_value: 8'd0,
                               wait_window: wait_w};
      n = n + 4'd1;
    end
    if (ln_en) begin
      plan.entries[n[2:0]] = '{kind: KindLine, slot: 3'd0, from_restore: 1'b0,
                               palette_index: 5'd0, line_value: ln_val, wait_window: 1'b0};
      n = n + 4'd1;
    end
    plan.count = n;
  end

  assign plan_o       = plan;
  assign plan_valid_o = a_valid_q && (plan.count != 4'd0);
  assign a_move       = a_valid_q && ((plan.count == 4'd0) || plan_ready_i);
  assign in_stall_o   = a_valid_q && !a_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      phase_q   <= '0;
    end else begin
      if (a_move) begin
        phase_q <= phase_d;
      end
      if (!in_stall_o) begin
        a_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_action_q <= action_i;
      a_line_q   <= current_line_i;
    end
  end

endmodule

### hdl/bps_emit.sv
// Plan buffer and output register: sends one result per cycle while out_stall_i is low.
// Depends on bps_pkg.
module bps_emit
  import bps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  plan_valid_i,
  output logic  plan_ready_o,
  input  plan_t plan_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output entry_t entry_o,
  output logic  last_o
);

  logic       b_valid_q;
  plan_t      b_plan_q;
  logic [2:0] b_idx_q;
  logic       c_valid_q;
  entry_t     c_entry_q;
  logic       c_last_q;
  logic       cur_last;
  logic       c_load;
  logic       b_done;

  assign cur_last     = ({1'b0, b_idx_q} + 4'd1) == b_plan_q.count;
  assign c_load       = b_valid_q && (!c_valid_q || !out_stall_i);
  assign b_done       = c_load && cur_last;
  assign plan_ready_o = !b_valid_q || b_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_idx_q   <= '0;
      c_valid_q <= 1'b0;
    end else begin
      if (plan_valid_i && plan_ready_o) begin
        b_valid_q <= 1'b1;
        b_idx_q   <= '0;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end else if (c_load) begin
        b_idx_q <= b_idx_q + 3'd1;
      end
      if (c_load) begin
        c_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        c_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_valid_i && plan_ready_o) begin
      b_plan_q <= plan_i;
    end
    if (c_load) begin
      c_entry_q <= b_plan_q.entries[b_idx_q];
      c_last_q  <= cur_last;
    end
  end

  assign out_valid_o = c_valid_q;
  assign entry_o     = c_entry_q;
  assign last_o      = c_last_q;

endmodule

### hdl/band_palette_stream_sequencer.sv
// Top level of the palette band sequencer: config, planner and emitter.
// Depends on bps_pkg, bps_cfg, bps_plan, bps_emit and assert_macros.svh.
//
// channel  direction  handshake                 payload
// cfg      in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_stall_o     action_i, current_line_i
// out      out        out_valid_o/out_stall_i   kind_o .. last_o
//
// An event is held in the input register, then in the plan buffer, and its
// N results (0 to 8) leave one per cycle from the output register while
// out_stall_i is low; the single output port sets the event rate. Reset
// clears the config, the phase counter and all valid flags. An output stall
// backs up through the plan buffer to in_stall_o.
`include "assert_macros.svh"

module band_palette_stream_sequencer
  import bps_pkg::*;
#(
  parameter int MAX_BANDS = MaxBandsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] current_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [2:0] slot_o,
  output logic       from_restore_o,
  output logic [4:0] palette_index_o,
  output logic [7:0] line_value_o,
  output logic       wait_window_o,
  output logic       last_o
);

  cfg_t   cfg;
  plan_t  plan;
  logic   plan_valid;
  logic   plan_ready;
  entry_t entry;

  bps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bps_plan #(
    .MAX_BANDS (MAX_BANDS)
  ) u_plan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .current_line_i (current_line_i),
    .plan_valid_o   (plan_valid),
    .plan_ready_i   (plan_ready),
    .plan_o         (plan)
  );

  bps_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (plan_valid),
    .plan_ready_o (plan_ready),
    .plan_i       (plan),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_o      (entry),
    .last_o       (last_o)
  );

  assign kind_o          = entry.kind;
  assign slot_o          = entry.slot;
  assign from_restore_o  = entry.from_restore;
  assign palette_index_o = entry.palette_index;
  assign line_value_o    = entry.line_value;
  assign wait_window_o   = entry.wait_window;

  `ASSERT_NOW(a_line_is_last, clk_i, rst_ni, out_valid_o && kind_o, last_o)
  `ASSERT_NOW(a_line_clean, clk_i, rst_ni, out_valid_o && kind_o,
              slot_o == 3'd0 && !from_restore_o && palette_index_o == 5'd0 && !wait_window_o)
  `ASSERT_NOW(a_write_clean, clk_i, rst_ni, out_valid_o && !kind_o,
              line_value_o == 8'd0 && slot_o != 3'd7)
  `ASSERT_NOW(a_slot6_restore, clk_i, rst_ni, out_valid_o && !kind_o && slot_o == RestoreSlot,
              from_restore_o && palette_index_o == 5'd6)

endmodule

### bench/band_palette_stream_sequencer_tb.sv
// Self-checking bench for band_palette_stream_sequencer: directed rows, random frames, then a long receiver hold-off.
// Expected palette uploads come from an in-bench schedule model.
// Depends on bps_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps

module band_palette_stream_sequencer_tb;
  import bps_pkg::*;

  localparam int MaxBands      = MaxBandsDefault;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 3000;
  localparam int FramePhases   = 12;
  localparam int ItemsPerPhase = 27;

  localparam logic       EvBlank   = 1'b0;
  localparam logic       EvCompare = 1'b1;
  localparam logic [2:0] CfgSpare  = 3'd7;

  typedef enum logic [1:0] {ChkModel, ChkNone, ChkFirst} chk_e;
  typedef enum logic {RowCfg, RowEvt} row_e;

  typedef struct packed {
    entry_t ent;
    logic   last;
  } upload_t;

  typedef struct packed {
    row_e       op;
    logic [2:0] idx;
    logic [7:0] data;
    logic       act;
    logic [7:0] line;
    chk_e       chk;
    upload_t    first;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       action_i = 1'b0;
  logic [7:0] current_line_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       kind_o;
  logic [2:0] slot_o;
  logic       from_restore_o;
  logic [4:0] palette_index_o;
  logic [7:0] line_value_o;
  logic       wait_window_o;
  logic       last_o;

  band_palette_stream_sequencer #(
    .MAX_BANDS(MaxBands)
  ) uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .action_i, .current_line_i,
    .out_valid_o, .out_stall_i, .kind_o, .slot_o, .from_restore_o,
    .palette_index_o, .line_value_o, .wait_window_o, .last_o
  );

  always #2 clk_i = ~clk_i;

  // schedule model state
  logic       m_enable = 1'b0;
  logic       m_restore = 1'b0;
  logic [7:0] m_first = '0;
  logic [7:0] m_end = '0;
  logic [3:0] m_bands = '0;
  logic [3:0] m_phase = '0;
  logic       cur_wait;

  upload_t batch_q[$];
  upload_t sched_q[$];
  row_t    plan_rows[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet = 0;

  function automatic void add_pal(input logic [2:0] slot, input logic fr,
                                  input logic [4:0] idx);
    upload_t u;
    u = '0;
    u.ent.kind = KindPal;
    u.ent.slot = slot;
    u.ent.from_restore = fr;
    u.ent.palette_index = idx;
    u.ent.wait_window = cur_wait;
    batch_q.push_back(u);
  endfunction

  function automatic void add_line(input logic [7:0] value);
    upload_t u;
    u = '0;
    u.ent.kind = KindLine;
    u.ent.line_value = value;
    batch_q.push_back(u);
  endfunction

  function automatic void add_half(input logic [2:0] base);
    add_pal(base, 1'b1, {2'b00, base});
    add_pal(base + 3'd1, 1'b1, {2'b00, base + 3'd1});
    add_pal(base + 3'd2, 1'b1, {2'b00, base + 3'd2});
  endfunction

  function automatic void add_band(input int band);
    logic [2:0] base;
    logic [4:0] ix;
    base = (band % 2 != 0) ? HalfB : 3'd0;
    ix = 5'(band * 3);
    add_pal(base, 1'b0, ix);
    add_pal(base + 3'd1, 1'b0, ix + 5'd1);
    add_pal(base + 3'd2, 1'b0, ix + 5'd2);
  endfunction

  function automatic logic [3:0] bump(input int ph);
    return (ph >= 15) ? 4'd15 : 4'(ph + 1);
  endfunction

  function automatic void lead_in(input int bands);
    add_band(0);
    if (bands > 1) add_band(1);
    m_phase = 4'd2;
    if (bands > 2) begin
      add_line(m_first + BandLines);
    end else if (m_restore) begin
      add_line(m_end - BandLines);
      m_phase = 4'(bands);
    end
  endfunction

  // Fills batch_q with the uploads one event causes and advances the phase.
  function automatic void plan_uploads(input logic act, input logic [7:0] line);
    int bands;
    int ph;
    upload_t u;
    bands = (m_bands > MaxBands) ? MaxBands : m_bands;
    ph = m_phase;
    batch_q.delete();
    cur_wait = (line < WaitLine);
    if (!m_enable) return;
    if (act == EvBlank) begin
      if (m_restore) begin
        add_half(3'd0);
        add_half(HalfB);
        add_pal(RestoreSlot, 1'b1, {2'b00, RestoreSlot});
        m_phase = 4'd0;
        add_line(m_first - BandLines);
      end else begin
        lead_in(bands);
      end
    end else if (ph == 0) begin
      lead_in(bands);
    end else if (ph < bands) begin
      add_band(ph);
      m_phase = bump(ph);
      if (ph + 1 < bands) begin
        add_line(8'(m_first + ph * 8));
      end else if (m_restore) begin
        add_line(m_end - BandLines);
      end
    end else if (m_restore && ph == bands) begin
      add_half((bands % 2 != 0) ? HalfB : 3'd0);
      add_pal(RestoreSlot, 1'b1, {2'b00, RestoreSlot});
      m_phase = bump(ph);
      add_line(m_end);
    end else if (m_restore && ph == bands + 1) begin
      add_half((bands % 2 != 0) ? 3'd0 : HalfB);
      m_phase = bump(ph);
    end
    if (batch_q.size() > 0) begin
      u = batch_q.pop_back();
      u.last = 1'b1;
      batch_q.push_back(u);
    end
  endfunction

  function automatic upload_t write_of(input logic [2:0] slot, input logic fr,
                                       input logic [4:0] idx, input logic ww);
    upload_t u;
    u = '0;
    u.ent.kind = KindPal;
    u.ent.slot = slot;
    u.ent.from_restore = fr;
    u.ent.palette_index = idx;
    u.ent.wait_window = ww;
    return u;
  endfunction

  function automatic void add_cfg_row(input logic [2:0] idx, input logic [7:0] data);
    row_t r;
    r = '0;
    r.op = RowCfg;
    r.idx = idx;
    r.data = data;
    plan_rows.push_back(r);
  endfunction

  function automatic void add_evt_row(input logic act, input logic [7:0] line,
                                      input chk_e chk, input upload_t first);
    row_t r;
    r = '0;
    r.op = RowEvt;
    r.act = act;
    r.line = line;
    r.chk = chk;
    r.first = first;
    plan_rows.push_back(r);
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:         m_enable = data[0];
      CFG_FIRST_LINE:     m_first = data;
      CFG_END_LINE:       m_end = data;
      CFG_BAND_COUNT:     m_bands = data[3:0];
      CFG_RESTORE_ENABLE: m_restore = data[0];
      default: ;
    endcase
  endtask

  task automatic offer(input logic act, input logic [7:0] line, input chk_e chk,
                       input upload_t first);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    current_line_i <= line;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    plan_uploads(act, line);
    if (chk == ChkFirst) begin
      sched_q.push_back(first);
      void'(batch_q.pop_front());
    end
    if (chk != ChkNone) begin
      while (batch_q.size() > 0) sched_q.push_back(batch_q.pop_front());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_setup(input int p);
    logic [7:0] f;
    logic [7:0] e;
    logic [3:0] b;
    logic       r;
    logic       en;
    f = 8'($urandom_range(255));
    e = 8'($urandom_range(255));
    b = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(MaxBands));
    r = 1'($urandom_range(1));
    en = ($urandom_range(7) != 0);
    if (p == 0) begin
      f = 8'h00; e = 8'h00; b = 4'd0; r = 1'b1; en = 1'b1;
    end else if (p == 1) begin
      f = 8'hff; e = 8'hff; b = 4'hf; r = 1'b1; en = 1'b1;
    end else if (p == 2) begin
      b = 4'(MaxBands); r = 1'b0; en = 1'b1;
    end
    write_reg(CFG_FIRST_LINE, f);
    write_reg(CFG_END_LINE, e);
    write_reg(CFG_BAND_COUNT, {4'd0, b});
    write_reg(CFG_RESTORE_ENABLE, {7'd0, r});
    write_reg(CFG_ENABLE, {7'd0, en});
  endtask

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    upload_t want;
    logic    moved;
    if (rst_ni) begin
      moved = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
              (cfg_valid_i && cfg_ready_o);
      if (out_valid_o && !out_stall_i) begin
        if (sched_q.size() == 0) begin
          $display("%0t ns: unexpected item kind=%0d slot=%0d idx=%0d line=%0d",
                   $time, kind_o, slot_o, palette_index_o, line_value_o);
          mismatches++;
        end else begin
          want = sched_q.pop_front();
          check_field("kind", 8'(want.ent.kind), 8'(kind_o));
          check_field("slot", 8'(want.ent.slot), 8'(slot_o));
          check_field("from_restore", 8'(want.ent.from_restore), 8'(from_restore_o));
          check_field("palette_index", 8'(want.ent.palette_index), 8'(palette_index_o));
          check_field("line_value", want.ent.line_value, line_value_o);
          check_field("wait_window", 8'(want.ent.wait_window), 8'(wait_window_o));
          check_field("last", 8'(want.last), 8'(last_o));
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t       r;
    int         p;
    int         k;
    int         nev;
    int         counted;
    logic       act;
    logic [7:0] line;

    // disabled after reset
    add_evt_row(EvBlank, 8'd0, ChkNone, '0);
    add_evt_row(EvCompare, 8'd153, ChkNone, '0);
    add_cfg_row(CFG_FIRST_LINE, 8'd40);
    add_cfg_row(CFG_END_LINE, 8'd104);
    add_cfg_row(CFG_BAND_COUNT, 8'(MaxBands));
    add_cfg_row(CFG_RESTORE_ENABLE, 8'd0);
    add_cfg_row(CFG_ENABLE, 8'd1);
    add_cfg_row(CfgSpare, 8'hff);
    // full band walk, no restore
    add_evt_row(EvBlank, 8'd150, ChkFirst, write_of(3'd0, 1'b0, 5'd0, 1'b0));
    add_evt_row(EvCompare, 8'd0, ChkModel, '0);
    add_evt_row(EvCompare, 8'd20, ChkModel, '0);
    add_evt_row(EvCompare, 8'd60, ChkModel, '0);
    add_evt_row(EvCompare, 8'd100, ChkModel, '0);
    add_evt_row(EvCompare, 8'd142, ChkModel, '0);
    add_evt_row(EvCompare, 8'd143, ChkModel, '0);
    add_evt_row(EvCompare, 8'd153, ChkModel, '0);
    // restore phases after the last band, then idle
    add_cfg_row(CFG_RESTORE_ENABLE, 8'd1);
    add_evt_row(EvCompare, 8'd30, ChkModel, '0);
    add_evt_row(EvCompare, 8'd31, ChkModel, '0);
    add_evt_row(EvCompare, 8'd32, ChkModel, '0);
    add_evt_row(EvBlank, 8'd142, ChkFirst, write_of(3'd0, 1'b1, 5'd0, 1'b1));
    add_evt_row(EvCompare, 8'd10, ChkModel, '0);
    // single odd band
    add_cfg_row(CFG_BAND_COUNT, 8'd1);
    add_evt_row(EvBlank, 8'd60, ChkFirst, write_of(3'd0, 1'b1, 5'd0, 1'b1));
    add_evt_row(EvCompare, 8'd61, ChkModel, '0);
    add_evt_row(EvCompare, 8'd62, ChkModel, '0);
    add_evt_row(EvCompare, 8'd63, ChkModel, '0);
    add_evt_row(EvCompare, 8'd64, ChkModel, '0);
    // line wrap and band count above the maximum
    add_cfg_row(CFG_FIRST_LINE, 8'd0);
    add_cfg_row(CFG_END_LINE, 8'd255);
    add_cfg_row(CFG_BAND_COUNT, 8'd12);
    add_evt_row(EvBlank, 8'd0, ChkFirst, write_of(3'd0, 1'b1, 5'd0, 1'b1));
    add_evt_row(EvCompare, 8'd143, ChkModel, '0);
    // no bands
    add_cfg_row(CFG_BAND_COUNT, 8'd0);
    add_cfg_row(CFG_RESTORE_ENABLE, 8'd0);
    add_evt_row(EvBlank, 8'd77, ChkFirst, write_of(3'd0, 1'b0, 5'd0, 1'b1));
    add_evt_row(EvCompare, 8'd88, ChkModel, '0);
    add_cfg_row(CFG_ENABLE, 8'd0);
    add_evt_row(EvCompare, 8'd1, ChkNone, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_rows[i]) begin
      r = plan_rows[i];
      if (r.op == RowCfg) begin
        drain();
        write_reg(r.idx, r.data);
      end else begin
        offer(r.act, r.line, r.chk, r.first);
      end
    end

    for (p = 0; p < FramePhases; p++) begin
      drain();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      random_setup(p);
      counted = 0;
      while (counted < ItemsPerPhase) begin
        nev = ((m_bands > MaxBands) ? MaxBands : m_bands) + 2 + $urandom_range(1);
        for (k = 0; k < nev; k++) begin
          act = (k == 0) ? EvBlank : EvCompare;
          if ($urandom_range(9) == 0) act = 1'($urandom_range(1));
          line = 8'($urandom_range(153));
          offer(act, line, ChkModel, '0);
          counted += m_enable ? 1 : 4;
        end
      end
    end

    // long receiver hold-off so the block backs up into its input
    drain();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_BAND_COUNT, 8'(MaxBands));
    write_reg(CFG_RESTORE_ENABLE, 8'd1);
    write_reg(CFG_ENABLE, 8'd1);
    hold_left <= HoldCycles;
    repeat (24) offer(EvBlank, 8'($urandom_range(153)), ChkModel, '0);

    drain();
    if (mismatches == 0 && sched_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
